// ===== src/ffha_pkg.sv =====
package ffha_pkg;

    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int ADDR_BITS_DEF    = 20;

    typedef enum logic [2:0] {
        ST_REUSED       = 3'd0,
        ST_APPENDED     = 3'd1,
        ST_REFUSED      = 3'd2,
        ST_TOP_RELEASED = 3'd3,
        ST_MARKED_FREE  = 3'd4,
        ST_IGNORED      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic scan_run;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_full;
    } t_dp_sts;

endpackage

// ===== src/ffha_ctrl.sv =====
module ffha_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ffha_pkg::t_dp_sts i_sts,
    output ffha_pkg::t_dp_cmd o_cmd
);
    import ffha_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!i_sts.out_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
            end
            S_FINISH: begin
                o_cmd.finish = !i_sts.out_full;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== src/ffha_datapath.sv =====
module ffha_datapath #(
    parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int ADDR_BITS    = ffha_pkg::ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffha_pkg::t_dp_cmd     i_cmd,
    output ffha_pkg::t_dp_sts     o_sts,
    input  logic                  i_cfg_wr_en,
    input  logic [ADDR_BITS:0]    i_cfg_wr_data,
    input  logic                  i_action,
    input  logic [ADDR_BITS-1:0]  i_request_size,
    input  logic [ADDR_BITS-1:0]  i_payload_address,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ffha_pkg::t_status     o_status,
    output logic [ADDR_BITS-1:0]  o_result_address,
    output logic [ADDR_BITS-1:0]  o_granted_size
);
    import ffha_pkg::*;

    localparam int A  = ADDR_BITS;
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = IW + 1;
    localparam int WW = 2 * A + 1;
    localparam logic [CW-1:0]  MAX_CNT   = CW'(MAX_BLOCKS);
    localparam logic [A+1:0]   HDR       = (A + 2)'(HEADER_BYTES);
    localparam logic [A:0]     LIMIT_RST = (A + 1)'(1) << A;

    // entry word: {free, length, start}
    logic [WW-1:0] mem [MAX_BLOCKS];

    logic [A:0]    r_limit;
    logic [CW-1:0] r_count;
    logic [A:0]    r_top;

    logic          r_action;
    logic [A-1:0]  r_size;
    logic [A-1:0]  r_addr;

    logic [CW-1:0] r_ra;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic [WW-1:0] r_rd_word;

    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [WW-1:0] r_hit_word;

    logic          r_out_valid;
    t_status       r_out_status;
    logic [A-1:0]  r_out_addr;
    logic [A-1:0]  r_out_len;

    logic          is_null;
    logic          match;
    logic [A-1:0]  rd_start;
    logic [A-1:0]  rd_len;
    logic          rd_free;
    logic [A-1:0]  hit_start;
    logic [A-1:0]  hit_len;
    logic [A+1:0]  payload;
    logic [A+1:0]  new_top;
    logic          refuse;
    logic          is_last;

    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [WW-1:0] mem_wd;
    t_status       n_status;
    logic [A-1:0]  n_addr;
    logic [A-1:0]  n_len;
    logic [CW-1:0] n_count;
    logic [A:0]    n_top;

    assign rd_start  = r_rd_word[A-1:0];
    assign rd_len    = r_rd_word[2*A-1:A];
    assign rd_free   = r_rd_word[2*A];
    assign hit_start = r_hit_word[A-1:0];
    assign hit_len   = r_hit_word[2*A-1:A];

    assign is_null = r_action ? (r_addr == '0) : (r_size == '0);
    assign match   = r_rd_vld && !is_null &&
                     (r_action ? (rd_start == r_addr) : (rd_free && (rd_len >= r_size)));

    assign o_sts.scan_done = match || (!r_rd_vld && (r_ra >= r_count));
    assign o_sts.out_full  = r_out_valid;

    assign payload = {1'b0, r_top} + HDR;
    assign new_top = payload + {2'b00, r_size};
    assign refuse  = (r_count >= MAX_CNT) || (new_top > {1'b0, r_limit}) ||
                     (payload[A+1:A] != 2'b00);
    assign is_last = (CW'(r_hit_idx) + CW'(1)) == r_count;

    always_comb begin
        mem_we   = 1'b0;
        mem_wa   = r_hit_idx;
        mem_wd   = r_hit_word;
        n_status = ST_IGNORED;
        n_addr   = '0;
        n_len    = '0;
        n_count  = r_count;
        n_top    = r_top;
        if (!r_action) begin
            if (is_null) begin
                n_status = ST_REFUSED;
            end else if (r_hit) begin
                mem_we   = 1'b1;
                mem_wd   = {1'b0, hit_len, hit_start};
                n_status = ST_REUSED;
                n_addr   = hit_start;
                n_len    = hit_len;
            end else if (refuse) begin
                n_status = ST_REFUSED;
            end else begin
                mem_we   = 1'b1;
                mem_wa   = r_count[IW-1:0];
                mem_wd   = {1'b0, r_size, payload[A-1:0]};
                n_status = ST_APPENDED;
                n_addr   = payload[A-1:0];
                n_len    = r_size;
                n_count  = r_count + CW'(1);
                n_top    = new_top[A:0];
            end
        end else if (!is_null && r_hit) begin
            n_len = hit_len;
            if (is_last) begin
                n_status = ST_TOP_RELEASED;
                n_count  = r_count - CW'(1);
                n_top    = {1'b0, hit_start} - HDR[A:0];
            end else begin
                mem_we   = 1'b1;
                mem_wd   = {1'b1, hit_len, hit_start};
                n_status = ST_MARKED_FREE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_run && (r_ra < r_count)) begin
            r_rd_word <= mem[r_ra[IW-1:0]];
            r_rd_idx  <= r_ra[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_size   <= i_request_size;
            r_addr   <= i_payload_address;
        end
        if (i_cmd.scan_run && match) begin
            r_hit_idx  <= r_rd_idx;
            r_hit_word <= r_rd_word;
        end
        if (i_cmd.finish) begin
            r_out_status <= n_status;
            r_out_addr   <= n_addr;
            r_out_len    <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RST;
            r_count     <= '0;
            r_top       <= '0;
            r_ra        <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (i_cmd.capture) begin
                r_ra     <= '0;
                r_rd_vld <= 1'b0;
                r_hit    <= 1'b0;
            end else if (i_cmd.scan_run) begin
                if (r_ra < r_count) begin
                    r_ra     <= r_ra + CW'(1);
                    r_rd_vld <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b0;
                end
                if (match) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_top       <= n_top;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_result_address = r_out_addr;
    assign o_granted_size   = r_out_len;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("block count above table depth");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_top == '0))
        else $error("empty table with nonzero heap top");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !r_out_valid)
        else $error("result written over a waiting item");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_run |-> (r_ra <= r_count))
        else $error("scan pointer past block count");

    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("finished item not presented");

endmodule

// ===== src/first_fit_heap_allocator.sv =====
// Operation: the table is scanned one entry per cycle up to the first hit, or over all
//   live entries on a miss; the result is presented after the scan, later while an
//   earlier result still waits. A new item is not accepted until the last result is registered.
// Reset (i_rst_n low, synchronous): table empty, heap top 0, limit 2**ADDR_BITS,
//   no result pending. Table contents are not cleared; only live entries are read.
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int ADDR_BITS    = ffha_pkg::ADDR_BITS_DEF,
    parameter int DATA_W       = ((2 * ADDR_BITS + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ADDR_BITS:0] i_cfg_wr_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // request_size, payload_address
    input  logic [DATA_W-1:0] s_axis_tdata,
    // action
    input  logic [0:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // result_address, granted_size
    output logic [DATA_W-1:0] m_axis_tdata,
    // status
    output logic [2:0]        m_axis_tuser
);
    import ffha_pkg::*;

    t_dp_cmd              cmd;
    t_dp_sts              sts;
    t_status              status;
    logic [ADDR_BITS-1:0] result_address;
    logic [ADDR_BITS-1:0] granted_size;

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ffha_datapath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_action          (s_axis_tuser[0]),
        .i_request_size    (s_axis_tdata[ADDR_BITS-1:0]),
        .i_payload_address (s_axis_tdata[2*ADDR_BITS-1:ADDR_BITS]),
        .o_out_valid       (m_axis_tvalid),
        .i_out_ready       (m_axis_tready),
        .o_status          (status),
        .o_result_address  (result_address),
        .o_granted_size    (granted_size)
    );

    assign m_axis_tdata = DATA_W'({granted_size, result_address});
    assign m_axis_tuser = status;

endmodule
